// File: src/lfu_pkg.sv
// Shared types and constants for the LFU cache with LRU tie-break.
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;

    localparam int KEY_W   = 32;
    localparam int DATA_W  = 31;
    localparam int COUNT_W = 32;
    localparam int CAP_W   = 5;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;
    localparam int REG_IW  = APB_AW - 2;

    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    localparam logic [REG_IW-1:0] REG_CAPACITY = 1'd0;
    localparam logic [CAP_W-1:0]  CAPACITY_RST = 5'd16;

    typedef struct packed {
        logic found;
        logic have_victim;
        logic have_free;
    } scan_flags_t;

    typedef enum logic [1:0] {
        UPD_NONE,
        UPD_TOUCH,
        UPD_INSERT
    } upd_mode_t;

endpackage
`default_nettype wire

// File: src/lfu_mem.sv
// Entry storage: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module lfu_mem
    import lfu_pkg::*;
#(
    parameter int N  = 16,
    parameter int IW = 4,
    parameter int RW = 4
)
(
    input  wire logic               clk,
    input  wire logic               rd_en,
    input  wire logic [IW-1:0]      rd_addr,
    output logic                    rd_valid,
    output logic [KEY_W-1:0]        rd_key,
    output logic [DATA_W-1:0]       rd_data,
    output logic [COUNT_W-1:0]      rd_count,
    output logic [RW-1:0]           rd_rank,
    input  wire logic               wr_en,
    input  wire logic [IW-1:0]      wr_addr,
    input  wire logic               wr_valid,
    input  wire logic [KEY_W-1:0]   wr_key,
    input  wire logic [DATA_W-1:0]  wr_data,
    input  wire logic [COUNT_W-1:0] wr_count,
    input  wire logic [RW-1:0]      wr_rank
);

    logic               valid_mem [N];
    logic [KEY_W-1:0]   key_mem   [N];
    logic [DATA_W-1:0]  data_mem  [N];
    logic [COUNT_W-1:0] count_mem [N];
    logic [RW-1:0]      rank_mem  [N];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            valid_mem[wr_addr] <= wr_valid;
            key_mem[wr_addr]   <= wr_key;
            data_mem[wr_addr]  <= wr_data;
            count_mem[wr_addr] <= wr_count;
            rank_mem[wr_addr]  <= wr_rank;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_valid <= valid_mem[rd_addr];
            rd_key   <= key_mem[rd_addr];
            rd_data  <= data_mem[rd_addr];
            rd_count <= count_mem[rd_addr];
            rd_rank  <= rank_mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: src/lfu_scan.sv
// Compare unit: accumulates hit, victim and first free slot over a scan.
`timescale 1ns / 1ps
`default_nettype none
module lfu_scan
    import lfu_pkg::*;
#(
    parameter int IW = 4,
    parameter int RW = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               clr,
    input  wire logic               en,
    input  wire logic [IW-1:0]      idx,
    input  wire logic [KEY_W-1:0]   key,
    input  wire logic               e_valid,
    input  wire logic [KEY_W-1:0]   e_key,
    input  wire logic [DATA_W-1:0]  e_data,
    input  wire logic [COUNT_W-1:0] e_count,
    input  wire logic [RW-1:0]      e_rank,
    output scan_flags_t             flags,
    output logic [IW-1:0]           hit_idx,
    output logic [RW-1:0]           hit_rank,
    output logic [DATA_W-1:0]       hit_data,
    output logic [IW-1:0]           victim_idx,
    output logic [RW-1:0]           victim_rank,
    output logic [KEY_W-1:0]        victim_key,
    output logic [IW-1:0]           free_idx
);

    scan_flags_t        flags_reg;
    logic [IW-1:0]      hit_idx_reg;
    logic [RW-1:0]      hit_rank_reg;
    logic [DATA_W-1:0]  hit_data_reg;
    logic [IW-1:0]      victim_idx_reg;
    logic [RW-1:0]      victim_rank_reg;
    logic [KEY_W-1:0]   victim_key_reg;
    logic [COUNT_W-1:0] victim_count_reg;
    logic [IW-1:0]      free_idx_reg;

    logic take_hit;
    logic take_victim;
    logic take_free;

    assign take_hit    = en && !flags_reg.found && e_valid && (e_key == key);
    assign take_victim = en && e_valid && (!flags_reg.have_victim
                         || (e_count < victim_count_reg)
                         || ((e_count == victim_count_reg) && (e_rank > victim_rank_reg)));
    assign take_free   = en && !flags_reg.have_free && !e_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (clr)
        begin
            flags_reg <= '0;
        end
        else
        begin
            if (take_hit)
                flags_reg.found <= 1'b1;
            if (take_victim)
                flags_reg.have_victim <= 1'b1;
            if (take_free)
                flags_reg.have_free <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_hit)
        begin
            hit_idx_reg  <= idx;
            hit_rank_reg <= e_rank;
            hit_data_reg <= e_data;
        end
        if (take_victim)
        begin
            victim_idx_reg   <= idx;
            victim_rank_reg  <= e_rank;
            victim_key_reg   <= e_key;
            victim_count_reg <= e_count;
        end
        if (take_free)
            free_idx_reg <= idx;
    end

    assign flags       = flags_reg;
    assign hit_idx     = hit_idx_reg;
    assign hit_rank    = hit_rank_reg;
    assign hit_data    = hit_data_reg;
    assign victim_idx  = victim_idx_reg;
    assign victim_rank = victim_rank_reg;
    assign victim_key  = victim_key_reg;
    assign free_idx    = free_idx_reg;

endmodule
`default_nettype wire

// File: src/lfu_cache_lru_tiebreak.sv
// Top level: LFU key/value cache with LRU tie-break, sequencer and config port.
// The lookup scan reads every entry once through the single memory read port.
// The memory registers the read data, and the scan unit registers its flags from
// that data. Then comes the decide state and, when the command changes state,
// a read-modify-write pass over every entry. The finish state posts the result,
// and the idle state after it accepts the next transfer. A get miss or a put with
// capacity 0 skips the write pass. The next command is accepted once the previous
// one is posted, while its result may still wait in the output register. A command
// that reaches its post cycle while a result still waits stalls there until
// out_ready. After reset the block runs a clearing pass over every entry before
// in_ready first rises. Capacity is at byte address 0; values above MAX_ENTRIES
// act as MAX_ENTRIES.
`timescale 1ns / 1ps
`default_nettype none
module lfu_cache_lru_tiebreak
    import lfu_pkg::*;
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              command,
    input  wire logic [KEY_W-1:0]  key,
    input  wire logic [DATA_W-1:0] value,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   found,
    output logic [DATA_W-1:0]      read_value,
    output logic                   evicted,
    output logic [KEY_W-1:0]       evicted_key
);

    localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RW  = IW;
    localparam int NW  = IW + 1;
    localparam int HW  = $clog2(MAX_ENTRIES + 1);
    localparam int CW  = (HW > CAP_W) ? HW : CAP_W;
    localparam logic [NW-1:0] N_CNT = NW'(MAX_ENTRIES);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_UPDATE,
        ST_FINISH
    } state_t;

    state_t             state_reg;
    logic [NW-1:0]      cnt_reg;
    logic               pend_reg;
    logic [IW-1:0]      pend_idx_reg;
    logic [CAP_W-1:0]   capacity_reg;
    logic [HW-1:0]      held_reg;
    logic               cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [DATA_W-1:0]  value_reg;
    upd_mode_t          mode_reg;
    logic               evict_reg;
    logic [IW-1:0]      slot_reg;
    logic               res_found_reg;
    logic [DATA_W-1:0]  res_read_reg;
    logic [KEY_W-1:0]   res_evk_reg;
    logic               out_valid_reg;
    logic               out_found_reg;
    logic [DATA_W-1:0]  out_read_reg;
    logic               out_ev_reg;
    logic [KEY_W-1:0]   out_evk_reg;

    logic               rd_issue;
    logic               rd_valid;
    logic [KEY_W-1:0]   rd_key;
    logic [DATA_W-1:0]  rd_data;
    logic [COUNT_W-1:0] rd_count;
    logic [RW-1:0]      rd_rank;
    logic               wr_en;
    logic [IW-1:0]      wr_addr;
    logic               wr_valid;
    logic [KEY_W-1:0]   wr_key;
    logic [DATA_W-1:0]  wr_data;
    logic [COUNT_W-1:0] wr_count;
    logic [RW-1:0]      wr_rank;

    scan_flags_t        flags;
    logic [IW-1:0]      hit_idx;
    logic [RW-1:0]      hit_rank;
    logic [DATA_W-1:0]  hit_data;
    logic [IW-1:0]      victim_idx;
    logic [RW-1:0]      victim_rank;
    logic [KEY_W-1:0]   victim_key;
    logic [IW-1:0]      free_idx;

    logic               accept;
    logic               cfg_wr;
    logic [CW-1:0]      cap_eff;
    logic               is_put;
    logic               do_touch;
    logic               do_insert;
    logic               do_evict;
    logic [IW-1:0]      slot_pick;
    logic               post;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && (paddr[APB_AW-1:2] == REG_CAPACITY);
    assign prdata   = (paddr[APB_AW-1:2] == REG_CAPACITY)
                      ? APB_DW'(capacity_reg) : '0;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign rd_issue = ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE)) && (cnt_reg < N_CNT);
    assign post     = (state_reg == ST_FINISH) && (!out_valid_reg || out_ready);

    assign cap_eff   = (CW'(capacity_reg) > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES)
                       : CW'(capacity_reg);
    assign is_put    = (cmd_reg == CMD_PUT);
    assign do_touch  = flags.found && (!is_put || (cap_eff != '0));
    assign do_insert = !flags.found && is_put && (cap_eff != '0);
    assign do_evict  = do_insert && (CW'(held_reg) >= cap_eff) && flags.have_victim;
    assign slot_pick = (do_evict && !(flags.have_free && (free_idx < victim_idx)))
                       ? victim_idx : free_idx;

    lfu_mem #(
        .N  (MAX_ENTRIES),
        .IW (IW),
        .RW (RW)
    ) u_mem (
        .clk      (clk),
        .rd_en    (rd_issue),
        .rd_addr  (cnt_reg[IW-1:0]),
        .rd_valid (rd_valid),
        .rd_key   (rd_key),
        .rd_data  (rd_data),
        .rd_count (rd_count),
        .rd_rank  (rd_rank),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_valid (wr_valid),
        .wr_key   (wr_key),
        .wr_data  (wr_data),
        .wr_count (wr_count),
        .wr_rank  (wr_rank)
    );

    lfu_scan #(
        .IW (IW),
        .RW (RW)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .clr         (accept),
        .en          (pend_reg && (state_reg == ST_SCAN)),
        .idx         (pend_idx_reg),
        .key         (key_reg),
        .e_valid     (rd_valid),
        .e_key       (rd_key),
        .e_data      (rd_data),
        .e_count     (rd_count),
        .e_rank      (rd_rank),
        .flags       (flags),
        .hit_idx     (hit_idx),
        .hit_rank    (hit_rank),
        .hit_data    (hit_data),
        .victim_idx  (victim_idx),
        .victim_rank (victim_rank),
        .victim_key  (victim_key),
        .free_idx    (free_idx)
    );

    // write-back of one entry per cycle
    always_comb
    begin
        wr_en    = 1'b0;
        wr_addr  = pend_idx_reg;
        wr_valid = rd_valid;
        wr_key   = rd_key;
        wr_data  = rd_data;
        wr_count = rd_count;
        wr_rank  = rd_rank;
        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = (cnt_reg < N_CNT);
                wr_addr  = cnt_reg[IW-1:0];
                wr_valid = 1'b0;
            end
            ST_UPDATE:
            begin
                wr_en = pend_reg;
                if (mode_reg == UPD_TOUCH)
                begin
                    if (pend_idx_reg == hit_idx)
                    begin
                        wr_rank  = '0;
                        wr_count = (rd_count == '1) ? rd_count : rd_count + 1'b1;
                        if (is_put)
                            wr_data = value_reg;
                    end
                    else if (rd_valid && (rd_rank < hit_rank))
                    begin
                        wr_rank = rd_rank + 1'b1;
                    end
                end
                else
                begin
                    if (pend_idx_reg == slot_reg)
                    begin
                        wr_valid = 1'b1;
                        wr_key   = key_reg;
                        wr_data  = value_reg;
                        wr_count = COUNT_W'(1);
                        wr_rank  = '0;
                    end
                    else if (evict_reg && (pend_idx_reg == victim_idx))
                    begin
                        wr_valid = 1'b0;
                    end
                    else if (rd_valid && !(evict_reg && (rd_rank > victim_rank)))
                    begin
                        wr_rank = rd_rank + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAPACITY_RST;
        end
        else if (cfg_wr)
        begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            held_reg      <= '0;
            mode_reg      <= UPD_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= rd_issue;
            if (post)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_CLEAR:
                begin
                    if (cnt_reg < N_CNT)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    else
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (rd_issue)
                        cnt_reg <= cnt_reg + 1'b1;
                    else if (!pend_reg)
                        state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    cnt_reg <= '0;
                    if (do_insert && !do_evict)
                        held_reg <= held_reg + 1'b1;
                    if (do_touch)
                    begin
                        mode_reg  <= UPD_TOUCH;
                        state_reg <= ST_UPDATE;
                    end
                    else if (do_insert)
                    begin
                        mode_reg  <= UPD_INSERT;
                        state_reg <= ST_UPDATE;
                    end
                    else
                    begin
                        mode_reg  <= UPD_NONE;
                        state_reg <= ST_FINISH;
                    end
                end
                ST_UPDATE:
                begin
                    if (rd_issue)
                        cnt_reg <= cnt_reg + 1'b1;
                    else if (!pend_reg)
                        state_reg <= ST_FINISH;
                end
                ST_FINISH:
                begin
                    if (post)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_issue)
            pend_idx_reg <= cnt_reg[IW-1:0];
        if (accept)
        begin
            cmd_reg   <= command;
            key_reg   <= key;
            value_reg <= value;
        end
        if (state_reg == ST_DECIDE)
        begin
            evict_reg     <= do_evict;
            slot_reg      <= slot_pick;
            res_found_reg <= flags.found;
            res_read_reg  <= (!is_put && flags.found) ? hit_data : '0;
            res_evk_reg   <= do_evict ? victim_key : '0;
        end
        if (post)
        begin
            out_found_reg <= res_found_reg;
            out_read_reg  <= res_read_reg;
            out_ev_reg    <= evict_reg && (mode_reg == UPD_INSERT);
            out_evk_reg   <= (mode_reg == UPD_INSERT) ? res_evk_reg : '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign found       = out_found_reg;
    assign read_value  = out_read_reg;
    assign evicted     = out_ev_reg;
    assign evicted_key = out_evk_reg;

endmodule
`default_nettype wire

// File: src/lfu_checker.sv
// Port-level checks for the LFU cache, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module lfu_checker
    import lfu_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic              found,
    input wire logic [DATA_W-1:0] read_value,
    input wire logic              evicted,
    input wire logic [KEY_W-1:0]  evicted_key
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(found) && $stable(read_value)
            && $stable(evicted) && $stable(evicted_key))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("new transfer accepted while busy");

    a_read_hit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (read_value != '0) |-> found)
        else $error("read value without a hit");

    a_evk: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (evicted_key != '0) |-> evicted)
        else $error("evicted key without eviction");

    a_ev_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && evicted |-> !found)
        else $error("eviction on a hit");

endmodule

bind lfu_cache_lru_tiebreak lfu_checker u_lfu_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key)
);
`default_nettype wire
